FILE: sv/wgm_pkg.sv
package wgm_pkg;

  localparam logic [7:0] SYM_ANY_ONE = 8'd63;  // '?'
  localparam logic [7:0] SYM_ANY_RUN = 8'd42;  // '*'

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_TEXT    = 2'd3
  } op_t;

  // Decoded command broadcast to every cell.
  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       append;
    logic       restart;
    logic       text;
    logic       symbol_is_star;
    logic [7:0] symbol;
  } ctl_t;

  // Signals handed from one cell to the next.
  typedef struct packed {
    logic carry;  // star closure reaching the next position
    logic step;   // byte consumed, next position becomes active
    logic term;   // end-of-pattern marker moving on append
  } link_t;

endpackage

FILE: sv/wgm_cell.sv
module wgm_cell
  import wgm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  lead,
  input  ctl_t  ctl,
  input  link_t up,
  output link_t down,
  output logic  hit,
  output logic  term_q
);

  logic [7:0] sym_q;
  logic       used;
  logic       act;
  logic       term;

  logic is_star;
  logic is_match;
  logic act_next;
  logic term_next;
  logic used_next;

  assign is_star  = used && (sym_q == SYM_ANY_RUN);
  assign is_match = used && !is_star &&
                    ((sym_q == SYM_ANY_ONE) || (sym_q == ctl.symbol));

  always_comb begin
    act_next  = act;
    term_next = term;
    used_next = used;
    down      = '0;
    if (ctl.clear) begin
      act_next  = up.step | up.carry;
      term_next = up.term;
      used_next = 1'b0;
    end else if (ctl.append) begin
      act_next   = act | up.carry;
      term_next  = up.term;
      used_next  = used | term;
      down.carry = act & term & ctl.symbol_is_star;
      down.term  = term;
    end else if (ctl.restart) begin
      act_next   = up.step | up.carry;
      down.carry = act_next & is_star;
    end else if (ctl.text) begin
      act_next   = (act & is_star) | up.step | up.carry;
      down.carry = act_next & is_star;
      down.step  = act & is_match;
    end
  end

  assign hit    = act_next & term_next;
  assign term_q = term;

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= lead;
      term <= lead;
      used <= 1'b0;
    end else if (ctl.accept) begin
      act  <= act_next;
      term <= term_next;
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept && ctl.append && term) begin
      sym_q <= ctl.symbol;
    end
  end

endmodule

FILE: sv/wildcard_glob_matcher.sv
// Glob matcher: load a pattern with append transfers ('?' matches any one byte, '*' matches any
// run including none), then stream text bytes; every accepted transfer returns one result that
// says whether the text since the last restart or clear matches the whole pattern, plus a sticky
// overflow flag once a pattern byte beyond PATTERN_MAX has been dropped. A new transfer is taken
// each cycle while the output side keeps up; each result is registered and appears in the cycle
// after acceptance. The cycle time is set by the star closure, which ripples through the
// row of PATTERN_MAX cells with one gate stage per cell, much like a carry chain. No clearing pass
// follows reset: the block accepts on the first cycle after rst drops.
module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] symbol,

  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       overflow
);

  ctl_t  ctl;
  op_t   op;
  logic  acc;

  // link[k] feeds cell k; link[PATTERN_MAX] feeds the end position.
  link_t link [PATTERN_MAX+1];
  logic [PATTERN_MAX:0] hit_vec;
  logic [PATTERN_MAX:0] term_vec;

  // Position PATTERN_MAX has no pattern byte of its own, so it lives here.
  logic act_end;
  logic term_end;
  logic act_end_next;
  logic term_end_next;
  logic overflow_next;

  // Take a new transfer whenever the output register is free or being drained.
  assign in_stall = out_valid && out_stall;
  assign acc      = in_valid && !in_stall;
  assign op       = op_t'(opcode);

  always_comb begin
    ctl                = '0;
    ctl.accept         = acc;
    ctl.symbol         = symbol;
    ctl.symbol_is_star = (symbol == SYM_ANY_RUN);
    case (op)
      OP_CLEAR:   ctl.clear   = 1'b1;
      OP_APPEND:  ctl.append  = 1'b1;
      OP_RESTART: ctl.restart = 1'b1;
      OP_TEXT:    ctl.text    = 1'b1;
      default:    ctl.text    = 1'b1;
    endcase
  end

  // Seed the head of the row: position 0 becomes active on clear and restart, and the
  // end-of-pattern marker comes back to position 0 on clear.
  always_comb begin
    link[0]       = '0;
    link[0].step  = ctl.clear | ctl.restart;
    link[0].term  = ctl.clear;
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    wgm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .lead   ((k == 0) ? 1'b1 : 1'b0),
      .ctl    (ctl),
      .up     (link[k]),
      .down   (link[k+1]),
      .hit    (hit_vec[k]),
      .term_q (term_vec[k])
    );
  end

  // End position: no byte, so no self-loop and no outgoing carry.
  always_comb begin
    act_end_next  = act_end;
    term_end_next = term_end;
    overflow_next = overflow;
    if (ctl.clear) begin
      act_end_next  = link[PATTERN_MAX].step | link[PATTERN_MAX].carry;
      term_end_next = link[PATTERN_MAX].term;
      overflow_next = 1'b0;
    end else if (ctl.append) begin
      act_end_next  = act_end | link[PATTERN_MAX].carry;
      // Hold the marker here once the pattern is full; drop further bytes.
      term_end_next = term_end | link[PATTERN_MAX].term;
      overflow_next = overflow | term_end;
    end else if (ctl.restart || ctl.text) begin
      act_end_next  = link[PATTERN_MAX].step | link[PATTERN_MAX].carry;
    end
  end

  assign hit_vec[PATTERN_MAX]  = act_end_next & term_end_next;
  assign term_vec[PATTERN_MAX] = term_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_end   <= 1'b0;
      term_end  <= 1'b0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
      matched   <= 1'b0;
    end else begin
      if (acc) begin
        act_end   <= act_end_next;
        term_end  <= term_end_next;
        overflow  <= overflow_next;
        out_valid <= 1'b1;
        // The pattern end lies at exactly one position, so an OR picks its state.
        matched   <= |hit_vec;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The end-of-pattern marker sits at exactly one position.
  a_term_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(term_vec))
    else $error("end-of-pattern marker not one-hot");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_overflow_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow) |-> $past(acc && (op == OP_APPEND) && term_end))
    else $error("overflow set without a dropped pattern byte");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (acc && (op == OP_CLEAR)) |=> (out_valid && matched && !overflow))
    else $error("clear must report an empty match without overflow");

endmodule
